>>> rtl/xtea_block_encrypt_top_defines.svh
// Assertion macros shared by the XTEA block encryptor checker.
`ifndef XTEA_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define XTEA_BLOCK_ENCRYPT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define XTEA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/xtea_pkg.sv
// Shared constants, register codes and round helper for the XTEA block encryptor.
package xtea_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned TDATA_W        = 2 * WORD_W;
    localparam int unsigned ROUNDS_DEFAULT = 32;
    localparam int unsigned CFG_INDEX_W    = 3;
    localparam int unsigned NUM_KEYS       = 4;

    localparam logic [WORD_W-1:0] DELTA_RESET = 32'h9E37_79B9;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY0  = 3'd0,
        REG_KEY1  = 3'd1,
        REG_KEY2  = 3'd2,
        REG_KEY3  = 3'd3,
        REG_DELTA = 3'd4
    } cfg_reg_t;

    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_set_t;

    // Feistel mixing term: ((v << 4) ^ (v >> 5)) + v, wrapping at 32 bits.
    function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

>>> rtl/xtea_block_encrypt_top.sv
// XTEA encryption, one 64-bit block per cycle, two pipeline stages per round.
// Throughput: one block per cycle; a stalled output freezes the whole pipeline.
// Each stage holds one half-round, with at most two 32-bit additions in series.
// Reset clears all stage valid bits, the key words to zero and the delta to 0x9E3779B9.
module xtea_block_encrypt_top #(
    parameter int unsigned ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]        cfg_wdata,
    // Plaintext stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [xtea_pkg::TDATA_W-1:0]       s_axis_tdata,   // plain_low [31:0], plain_high [63:32]
    // Ciphertext stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [xtea_pkg::TDATA_W-1:0]       m_axis_tdata    // cipher_low [31:0], cipher_high [63:32]
);
    import xtea_pkg::*;

    localparam int unsigned STAGES = 2 * ROUNDS;
    localparam int unsigned LAST   = STAGES - 1;

    // Configuration registers.
    key_set_t          key_reg;
    logic [WORD_W-1:0] delta_reg;

    // Pipeline stage registers.
    logic              valid_reg [STAGES];
    logic [WORD_W-1:0] v0_reg    [STAGES];
    logic [WORD_W-1:0] v1_reg    [STAGES];
    logic [WORD_W-1:0] sum_reg   [STAGES];

    logic [WORD_W-1:0] v0_next   [STAGES];
    logic [WORD_W-1:0] v1_next   [STAGES];
    logic [WORD_W-1:0] sum_next  [STAGES];

    logic              advance;

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance       = !valid_reg[LAST] || m_axis_tready;
    assign s_axis_tready = advance;

    // Configuration writes; indexes past the delta register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            delta_reg <= DELTA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY0:  key_reg[0] <= cfg_wdata;
                REG_KEY1:  key_reg[1] <= cfg_wdata;
                REG_KEY2:  key_reg[2] <= cfg_wdata;
                REG_KEY3:  key_reg[3] <= cfg_wdata;
                REG_DELTA: delta_reg  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic              in_valid;
            logic [WORD_W-1:0] in_v0;
            logic [WORD_W-1:0] in_v1;
            logic [WORD_W-1:0] in_sum;

            // Stage inputs come from the input stream or the stage before.
            if (s == 0)
            begin : g_first
                assign in_valid = s_axis_tvalid;
                assign in_v0    = s_axis_tdata[WORD_W-1:0];
                assign in_v1    = s_axis_tdata[TDATA_W-1:WORD_W];
                assign in_sum   = '0;
            end
            else
            begin : g_chain
                assign in_valid = valid_reg[s-1];
                assign in_v0    = v0_reg[s-1];
                assign in_v1    = v1_reg[s-1];
                assign in_sum   = sum_reg[s-1];
            end

            // Even stages update the first half and step the sum;
            // odd stages update the second half with the stepped sum.
            if ((s % 2) == 0)
            begin : g_half_a
                always_comb
                begin
                    v0_next[s]  = in_v0 + (xtea_mix(in_v1) ^ (in_sum + key_reg[in_sum[1:0]]));
                    v1_next[s]  = in_v1;
                    sum_next[s] = in_sum + delta_reg;
                end
            end
            else
            begin : g_half_b
                always_comb
                begin
                    v0_next[s]  = in_v0;
                    v1_next[s]  = in_v1 + (xtea_mix(in_v0) ^ (in_sum + key_reg[in_sum[12:11]]));
                    sum_next[s] = in_sum;
                end
            end

            // Valid bit of the stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (advance)
                begin
                    valid_reg[s] <= in_valid;
                end
            end

            // Stage payload.
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    v0_reg[s]  <= v0_next[s];
                    v1_reg[s]  <= v1_next[s];
                    sum_reg[s] <= sum_next[s];
                end
            end
        end
    endgenerate

    // The last stage is the output register.
    assign m_axis_tvalid = valid_reg[LAST];
    assign m_axis_tdata  = {v1_reg[LAST], v0_reg[LAST]};

endmodule

>>> rtl/xtea_checker.sv
// Port-level checker for the XTEA block encryptor, bound to the top level.
`include "xtea_block_encrypt_top_defines.svh"

module xtea_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [xtea_pkg::TDATA_W-1:0]  m_axis_tdata    // cipher_low [31:0], cipher_high [63:32]
);
    import xtea_pkg::*;

    // A result that is not taken stays in place, unchanged.
    `XTEA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // The input side is held off exactly when a finished result waits.
    `XTEA_ASSERT_NOW(a_ready_rule, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output state")

    // A new result only appears if the pipeline was moving when it was registered.
    `XTEA_ASSERT_NOW(a_fill_moves, $rose(m_axis_tvalid), $past(s_axis_tready), "output filled while pipeline was frozen")

endmodule

bind xtea_block_encrypt_top xtea_checker u_xtea_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
